// ===== rtl/plcr_pkg.sv =====
// Shared constants and palette tables for the piecewise linear color ramp.
// Holds stop values and stop colors of the ten palettes, and lookup functions.
// No dependencies.
package plcr_pkg;

  localparam int DEF_FRAC_BITS = 16;
  localparam int DEF_MAX_STOPS = 34;
  localparam int NUM_PAL       = 10;
  localparam int IN_W          = 18;
  localparam int IN_FRAC       = 16;
  localparam int SEL_W         = 4;
  localparam int RGB_W         = 24;

  localparam logic [1:0] REG_PALETTE = 2'd0;
  localparam logic [SEL_W-1:0] PAL_GENERIC = 4'd1;

  localparam int PAL_LEN [NUM_PAL] = '{19, 19, 25, 29, 15, 16, 11, 15, 19, 34};

  localparam int V_CUR [19] = '{0,1,2,3,4,5,7,9,12,15,18,21,24,27,30,36,42,48,56};
  localparam int V_WIND [25] = '{0,3,6,9,12,15,18,21,24,27,30,33,36,39,42,45,48,51,54,
    57,60,63,66,70,75};
  localparam int V_AIR [29] = '{0,5,10,14,18,22,26,29,32,35,38,41,44,47,50,53,56,59,62,
    65,68,71,74,78,82,86,90,95,100};
  localparam int V_SEA [15] = '{-2,2,6,10,15,19,23,27,32,36,40,44,48,52,56};
  localparam int V_PREC [16] = '{0,1,2,5,7,10,20,50,70,100,200,500,700,1000,2000,5000};
  localparam int V_CLOUD [11] = '{0,1,10,20,30,40,50,60,70,80,90};
  localparam int V_REFC [15] = '{0,5,10,15,20,25,30,35,40,45,50,55,60,65,70};
  localparam int V_CAPE [19] = '{0,5,10,15,20,30,45,60,100,150,200,300,500,700,1000,
    1500,2000,2500,3000};
  localparam int V_WINDY [34] = '{0,3,6,9,12,15,18,21,24,27,30,33,36,39,42,45,48,51,
    54,57,60,63,66,69,72,75,78,81,84,87,90,93,96,99};

  localparam logic [RGB_W-1:0] C_CUR [19] = '{
    24'hd90000,24'hd92a00,24'hd96e00,24'hd9b200,24'hd4d404,24'ha6d906,24'h06d9a0,
    24'h00d9b0,24'h00d9c0,24'h00aed0,24'h0083e0,24'h0057e0,24'h0000f0,24'h0400f0,
    24'h1c00f0,24'h4800f0,24'h6900f0,24'ha000f0,24'hf000f0};
  localparam logic [RGB_W-1:0] C_GEN [19] = '{
    24'h00d900,24'h2ad900,24'h6ed900,24'hb2d900,24'hd4d400,24'hd9a600,24'hd90000,
    24'hd90040,24'hd90060,24'hae0080,24'h8300a0,24'h5700c0,24'h0000d0,24'h0400e0,
    24'h0800e0,24'ha000e0,24'hc004c0,24'hc008a0,24'hc0a008};
  localparam logic [RGB_W-1:0] C_WIND [25] = '{
    24'h288CFF,24'h00AFFF,24'h00DCE1,24'h00F7B0,24'h00EA9C,24'h82F059,24'hF0F503,
    24'hFFED00,24'hFFDB00,24'hFFC700,24'hFFB400,24'hFF9800,24'hFF7E00,24'hF77800,
    24'hEC7814,24'hE4711E,24'hE06128,24'hDC5132,24'hD5453C,24'hCD3A46,24'hBE2C50,
    24'hB41A5A,24'hAA1464,24'h962878,24'h8C328C};
  localparam logic [RGB_W-1:0] C_AIR [29] = '{
    24'h283282,24'h273c8c,24'h264696,24'h2350a0,24'h1f5aaa,24'h1a64b4,24'h136ec8,
    24'h0c78e1,24'h0382e6,24'h0091e6,24'h009ee1,24'h00a6dc,24'h00b2d7,24'h00bed2,
    24'h28c8c8,24'h78d2aa,24'h8cdc78,24'ha0eb5f,24'hc8f550,24'hf3fb02,24'hffed00,
    24'hffdd00,24'hffc900,24'hffab00,24'hff8100,24'hf1780c,24'he26a23,24'hd5453c,
    24'hb53c59};
  localparam logic [RGB_W-1:0] C_SEA [15] = '{
    24'hcc04ae,24'h8f06e4,24'h486afa,24'h00ffff,24'h00d54b,24'h59d800,24'hf2fc00,
    24'hff1500,24'hff0000,24'hd80000,24'ha90000,24'h870000,24'h690000,24'h550000,
    24'h330000};
  localparam logic [RGB_W-1:0] C_PREC [16] = '{
    24'hffffff,24'hc8f0ff,24'hb4e6ff,24'h8cd3ff,24'h78caff,24'h6ec1ff,24'h64b8ff,
    24'h50a6ff,24'h469eff,24'h3c96ff,24'h328eff,24'h1e7eff,24'h1476f0,24'h0a6edc,
    24'h0064c8,24'h0052aa};
  localparam logic [RGB_W-1:0] C_CLOUD [11] = '{
    24'hffffff,24'hf0f0e6,24'he6e6dc,24'hdcdcd2,24'hc8c8b4,24'haaaa8c,24'h969678,
    24'h787864,24'h646450,24'h5a5a46,24'h505036};
  localparam logic [RGB_W-1:0] C_REFC [15] = '{
    24'hffffff,24'h06E8E4,24'h009BE9,24'h0400F3,24'h00F924,24'h06C200,24'h009100,
    24'hFAFB00,24'hEBB608,24'hFF9400,24'hFD0002,24'hD70000,24'hC20300,24'hF900FE,
    24'h945AC8};
  localparam logic [RGB_W-1:0] C_CAPE [19] = '{
    24'h0046c8,24'h0050f0,24'h005aff,24'h0069ff,24'h0078ff,24'h000cff,24'h00a1ff,
    24'h00b6fa,24'h00c9ee,24'h00e0da,24'h00e6b4,24'h82e678,24'h9bff3b,24'hffdc00,
    24'hffb700,24'hf37800,24'hd4440c,24'hc8201c,24'had0430};
  localparam logic [RGB_W-1:0] C_WINDY [34] = '{
    24'h6271B7,24'h3961A9,24'h4A94A9,24'h4D8D7B,24'h53A553,24'h53A553,24'h359F35,
    24'hA79D51,24'h9F7F3A,24'hA16C5C,24'hA16C5C,24'h813A4E,24'hAF5088,24'hAF5088,
    24'h754A93,24'h754A93,24'h6D61A3,24'h44698D,24'h44698D,24'h5C9098,24'h7D44A5,
    24'h7D44A5,24'h7D44A5,24'hE7D7D7,24'hE7D7D7,24'hE7D7D7,24'hDBD483,24'hDBD483,
    24'hDBD483,24'hCDC470,24'hCDC470,24'hCDC470,24'hCDC470,24'h808080};

  // Stop value of palette p, stop i; zero past the end of the palette.
  function automatic int pal_v(input int p, input int i);
    int r;
    r = 0;
    if (i >= 0 && i < PAL_LEN[p]) begin
      case (p)
        0, 1:    r = V_CUR[i];
        2:       r = V_WIND[i];
        3:       r = V_AIR[i];
        4:       r = V_SEA[i];
        5:       r = V_PREC[i];
        6:       r = V_CLOUD[i];
        7:       r = V_REFC[i];
        8:       r = V_CAPE[i];
        default: r = V_WINDY[i];
      endcase
    end
    return r;
  endfunction

  function automatic logic [RGB_W-1:0] pal_rgb(input int p, input int i);
    logic [RGB_W-1:0] r;
    r = '0;
    if (i >= 0 && i < PAL_LEN[p]) begin
      case (p)
        0:       r = C_CUR[i];
        1:       r = C_GEN[i];
        2:       r = C_WIND[i];
        3:       r = C_AIR[i];
        4:       r = C_SEA[i];
        5:       r = C_PREC[i];
        6:       r = C_CLOUD[i];
        7:       r = C_REFC[i];
        8:       r = C_CAPE[i];
        default: r = C_WINDY[i];
      endcase
    end
    return r;
  endfunction

endpackage

// ===== rtl/plcr_seg_cell.sv =====
// Segment search cell: owns segment IDX (stops IDX-1 and IDX) of every palette.
// Depends on plcr_pkg for palette tables.
module plcr_seg_cell import plcr_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int MAX_STOPS = DEF_MAX_STOPS,
  parameter int IDX       = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [FRAC_BITS:0]     in_f,
  input  logic [SEL_W-1:0]       in_sel,
  input  logic                   in_found,
  input  logic [FRAC_BITS+1:0]   in_a,
  input  logic [FRAC_BITS+1:0]   in_b,
  input  logic [RGB_W-1:0]       in_ca,
  input  logic [RGB_W-1:0]       in_cb,
  output logic                   out_valid,
  output logic [FRAC_BITS:0]     out_f,
  output logic [SEL_W-1:0]       out_sel,
  output logic                   out_found,
  output logic [FRAC_BITS+1:0]   out_a,
  output logic [FRAC_BITS+1:0]   out_b,
  output logic [RGB_W-1:0]       out_ca,
  output logic [RGB_W-1:0]       out_cb
);

  localparam int     PW    = FRAC_BITS + 2;
  localparam longint ONE_L = longint'(1) << FRAC_BITS;

  logic [PW-1:0]    a_tab      [NUM_PAL];
  logic [PW-1:0]    b_tab      [NUM_PAL];
  logic [RGB_W-1:0] ca_tab     [NUM_PAL];
  logic [RGB_W-1:0] cb_tab     [NUM_PAL];
  logic             active_tab [NUM_PAL];
  logic             last_tab   [NUM_PAL];

  for (genvar p = 0; p < NUM_PAL; p++) begin : g_pal
    localparam int     LEN   = (PAL_LEN[p] < MAX_STOPS) ? PAL_LEN[p] : MAX_STOPS;
    localparam longint CMAX  = longint'(pal_v(p, LEN - 1));
    localparam longint POS_A = (longint'(pal_v(p, IDX - 1)) * ONE_L) / CMAX;
    localparam longint POS_B = (longint'(pal_v(p, IDX)) * ONE_L) / CMAX;
    assign a_tab[p]      = PW'(POS_A);
    assign b_tab[p]      = PW'(POS_B);
    assign ca_tab[p]     = pal_rgb(p, IDX - 1);
    assign cb_tab[p]     = pal_rgb(p, IDX);
    assign active_tab[p] = (IDX < LEN);
    assign last_tab[p]   = (IDX == LEN - 1);
  end

  logic hit;

  always_comb begin
    hit = !in_found && active_tab[in_sel] &&
          (($signed(b_tab[in_sel]) > $signed({1'b0, in_f})) || last_tab[in_sel]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_f     <= in_f;
      out_sel   <= in_sel;
      out_found <= in_found || hit;
      out_a     <= hit ? a_tab[in_sel]  : in_a;
      out_b     <= hit ? b_tab[in_sel]  : in_b;
      out_ca    <= hit ? ca_tab[in_sel] : in_ca;
      out_cb    <= hit ? cb_tab[in_sel] : in_cb;
    end
  end

endmodule

// ===== rtl/plcr_div_cell.sv =====
// Weight divider cell: resolves one quotient bit of (f-a)*ONE/(b-a).
// Depends on plcr_pkg for widths.
module plcr_div_cell import plcr_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int BIT       = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic                 in_byp,
  input  logic [FRAC_BITS+1:0] in_r,
  input  logic [FRAC_BITS+1:0] in_d,
  input  logic [FRAC_BITS:0]   in_q,
  input  logic [RGB_W-1:0]     in_ca,
  input  logic [RGB_W-1:0]     in_cb,
  output logic                 out_valid,
  output logic                 out_byp,
  output logic [FRAC_BITS+1:0] out_r,
  output logic [FRAC_BITS+1:0] out_d,
  output logic [FRAC_BITS:0]   out_q,
  output logic [RGB_W-1:0]     out_ca,
  output logic [RGB_W-1:0]     out_cb
);

  localparam int RW = FRAC_BITS + 2;

  logic [RW-1:0] rs;
  logic          ge;

  always_comb begin
    // top bit needs no shift: the remainder starts at or below the divisor
    rs = (BIT == FRAC_BITS) ? in_r : {in_r[RW-2:0], 1'b0};
    ge = !in_byp && (rs >= in_d);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_byp <= in_byp;
      out_d   <= in_d;
      out_r   <= ge ? rs - in_d : rs;
      out_q   <= in_q | ((FRAC_BITS+1)'(ge) << BIT);
      out_ca  <= in_ca;
      out_cb  <= in_cb;
    end
  end

endmodule

// ===== rtl/plcr_blend.sv =====
// Channel blend: (ONE-w)*ca + w*cb per channel, scaled down by ONE.
// Two stages: products, then sum and shift. Depends on plcr_pkg.
module plcr_blend import plcr_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [FRAC_BITS:0] in_w,
  input  logic [RGB_W-1:0]   in_ca,
  input  logic [RGB_W-1:0]   in_cb,
  output logic               out_valid,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue
);

  localparam int                 PRW = FRAC_BITS + 9;
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  logic             prod_valid;
  logic [PRW-1:0]   prod_a [3];
  logic [PRW-1:0]   prod_b [3];
  logic [PRW-1:0]   sum    [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = prod_a[c] + prod_b[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else if (en) begin
      prod_valid <= in_valid;
      out_valid  <= prod_valid;
    end
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        prod_a[c] <= PRW'(ONE - in_w) * PRW'(in_ca[8*c +: 8]);
        prod_b[c] <= PRW'(in_w) * PRW'(in_cb[8*c +: 8]);
      end
      blue  <= sum[0][FRAC_BITS +: 8];
      green <= sum[1][FRAC_BITS +: 8];
      red   <= sum[2][FRAC_BITS +: 8];
    end
  end

endmodule

// ===== rtl/piecewise_linear_color_ramp.sv =====
// Pseudo-color ramp: maps a signed Q16 fraction (clamped to 0..1.0) to RGB by
// linear blending between the two stops of the selected palette that bracket
// it. One transaction is taken every clock unless the output stalls; a result
// passes the input register, the MAX_STOPS-1 segment search cells, the divider
// setup register, the FRAC_BITS+1 weight divider cells and the blend stages.
// The whole pipeline holds when out_ready is low with a result shown.
// palette_select sits at address 0 (reset 1, codes of ten and above use the
// generic palette); change it only while the pipeline is empty.
module piecewise_linear_color_ramp import plcr_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int MAX_STOPS = DEF_MAX_STOPS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [1:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [IN_W-1:0] fraction_q16,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             red,
  output logic [7:0]             green,
  output logic [7:0]             blue
);

  localparam int FW  = FRAC_BITS + 1;
  localparam int PW  = FRAC_BITS + 2;
  localparam int NS  = MAX_STOPS;
  localparam int ND  = FRAC_BITS + 2;
  localparam int SHL = (FRAC_BITS >= IN_FRAC) ? FRAC_BITS - IN_FRAC : 0;
  localparam int SHR = (FRAC_BITS < IN_FRAC) ? IN_FRAC - FRAC_BITS : 0;
  localparam logic [IN_FRAC:0] X_ONE = (IN_FRAC+1)'(1) << IN_FRAC;
  localparam logic [FW-1:0]    ONE   = FW'(1) << FRAC_BITS;

  logic [SEL_W-1:0] palette_select;
  logic             en;

  assign pready = 1'b1;
  assign prdata = 32'(palette_select);
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_select <= PAL_GENERIC;
    end else if (psel && penable && pwrite && paddr == REG_PALETTE) begin
      palette_select <= pwdata[SEL_W-1:0];
    end
  end

  // segment search row
  logic             s_valid [NS];
  logic [FW-1:0]    s_f     [NS];
  logic [SEL_W-1:0] s_sel   [NS];
  logic             s_found [NS];
  logic [PW-1:0]    s_a     [NS];
  logic [PW-1:0]    s_b     [NS];
  logic [RGB_W-1:0] s_ca    [NS];
  logic [RGB_W-1:0] s_cb    [NS];

  logic [IN_FRAC:0] x_clamp;

  always_comb begin
    if (fraction_q16 < 0) begin
      x_clamp = '0;
    end else if (fraction_q16 > $signed({1'b0, X_ONE})) begin
      x_clamp = X_ONE;
    end else begin
      x_clamp = fraction_q16[IN_FRAC:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid[0] <= 1'b0;
    end else if (en) begin
      s_valid[0] <= in_valid;
    end
    if (en) begin
      s_f[0]   <= FW'((64'(x_clamp) << SHL) >> SHR);
      s_sel[0] <= (palette_select < SEL_W'(NUM_PAL)) ? palette_select : PAL_GENERIC;
    end
  end

  assign s_found[0] = 1'b0;
  assign s_a[0]     = '0;
  assign s_b[0]     = '0;
  assign s_ca[0]    = '0;
  assign s_cb[0]    = '0;

  for (genvar k = 1; k < NS; k++) begin : g_seg
    plcr_seg_cell #(.FRAC_BITS(FRAC_BITS), .MAX_STOPS(MAX_STOPS), .IDX(k)) u_cell (
      .clk, .rst, .en,
      .in_valid (s_valid[k-1]), .in_f  (s_f[k-1]),  .in_sel (s_sel[k-1]),
      .in_found (s_found[k-1]), .in_a  (s_a[k-1]),  .in_b   (s_b[k-1]),
      .in_ca    (s_ca[k-1]),    .in_cb (s_cb[k-1]),
      .out_valid(s_valid[k]),   .out_f (s_f[k]),    .out_sel(s_sel[k]),
      .out_found(s_found[k]),   .out_a (s_a[k]),    .out_b  (s_b[k]),
      .out_ca   (s_ca[k]),      .out_cb(s_cb[k])
    );
  end

  // divider setup: degenerate segment or fraction at/below the lower stop bypass
  logic             d_valid [ND];
  logic             d_byp   [ND];
  logic [PW-1:0]    d_r     [ND];
  logic [PW-1:0]    d_d     [ND];
  logic [FW-1:0]    d_q     [ND];
  logic [RGB_W-1:0] d_ca    [ND];
  logic [RGB_W-1:0] d_cb    [ND];

  logic signed [PW-1:0] fa, fb, ff;
  logic                 degen, below;

  always_comb begin
    fa    = $signed(s_a[NS-1]);
    fb    = $signed(s_b[NS-1]);
    ff    = $signed({1'b0, s_f[NS-1]});
    degen = (fb <= fa);
    below = (ff <= fa);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid[0] <= 1'b0;
    end else if (en) begin
      d_valid[0] <= s_valid[NS-1];
    end
    if (en) begin
      d_byp[0] <= degen || below;
      d_r[0]   <= PW'(ff - fa);
      d_d[0]   <= PW'(fb - fa);
      d_q[0]   <= (degen && ff >= fb) ? ONE : '0;
      d_ca[0]  <= s_ca[NS-1];
      d_cb[0]  <= s_cb[NS-1];
    end
  end

  for (genvar j = 0; j < ND - 1; j++) begin : g_div
    plcr_div_cell #(.FRAC_BITS(FRAC_BITS), .BIT(FRAC_BITS - j)) u_cell (
      .clk, .rst, .en,
      .in_valid (d_valid[j]),   .in_byp (d_byp[j]),   .in_r (d_r[j]),
      .in_d     (d_d[j]),       .in_q   (d_q[j]),     .in_ca(d_ca[j]),
      .in_cb    (d_cb[j]),
      .out_valid(d_valid[j+1]), .out_byp(d_byp[j+1]), .out_r(d_r[j+1]),
      .out_d    (d_d[j+1]),     .out_q  (d_q[j+1]),   .out_ca(d_ca[j+1]),
      .out_cb   (d_cb[j+1])
    );
  end

  plcr_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
    .clk, .rst, .en,
    .in_valid (d_valid[ND-1]),
    .in_w     (d_q[ND-1]),
    .in_ca    (d_ca[ND-1]),
    .in_cb    (d_cb[ND-1]),
    .out_valid(out_valid),
    .red, .green, .blue
  );

endmodule

// ===== rtl/plcr_checker.sv =====
// Port-level checks for the color ramp: register port and flow control.
// Bound to piecewise_linear_color_ramp; depends on nothing else.
module plcr_checker (
  input logic        clk,
  input logic        rst,
  input logic [31:0] prdata,
  input logic        pready,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  red,
  input logic [7:0]  green,
  input logic [7:0]  blue
);

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

  a_prdata_width: assert property (@(posedge clk) disable iff (rst) prdata[31:4] == 28'd0)
    else $error("palette register reads back stray bits");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input side not held with a stalled result");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green) && $stable(blue))
    else $error("stalled result changed");

endmodule

bind piecewise_linear_color_ramp plcr_checker u_plcr_checker (
  .clk, .rst, .prdata, .pready, .in_ready, .out_valid, .out_ready, .red, .green, .blue
);

// ===== tb/tb_piecewise_linear_color_ramp.sv =====
// Testbench for the piecewise linear color ramp: drives fractions under several
// handshake idling phases and palette settings, and checks RGB against a predictor.
// Depends on plcr_pkg and rtl/piecewise_linear_color_ramp.sv.
`timescale 1ns / 100ps

class color_scoreboard;
  logic [23:0] expected_rgb[$];
  int          mismatches;

  // Palette stops as seen by the predictor; predict_rgb maps a select of ten or more to generic.
  static function int stop_val(int p, int i);
    return plcr_pkg::pal_v(p, i);
  endfunction

  static function logic [23:0] predict_rgb(logic [3:0] sel,
                                           logic signed [17:0] frac);
    longint one, x, f, a, b, w, cmax, mag, q;
    int p, len, i, k, sh;
    logic [23:0] ca, cb, r;
    longint xa, xb;
    one = 64'd1 << 16;
    p = (sel < 10) ? int'(sel) : 1;
    len = plcr_pkg::PAL_LEN[p];
    if (len > plcr_pkg::DEF_MAX_STOPS) len = plcr_pkg::DEF_MAX_STOPS;
    x = frac;
    if (x < 0) x = 0;
    if (x > 65536) x = 65536;
    f = x;
    cmax = stop_val(p, len - 1);
    a = 0; b = 0; ca = '0; cb = '0;
    for (i = 1; i < len; i++) begin
      for (k = 0; k < 2; k++) begin
        mag = stop_val(p, i - 1 + k);
        q = ((mag < 0 ? -mag : mag) << 16) / cmax;
        if (mag < 0) q = -q;
        if (k == 0) a = q; else b = q;
      end
      if (b > f || i == len - 1) begin
        ca = plcr_pkg::pal_rgb(p, i - 1);
        cb = plcr_pkg::pal_rgb(p, i);
        break;
      end
    end
    if (b <= a) w = (f >= b) ? one : 0;
    else if (f <= a) w = 0;
    else begin
      w = ((f - a) << 16) / (b - a);
      if (w > one) w = one;
    end
    for (k = 0; k < 3; k++) begin
      sh = 16 - 8 * k;
      xa = (ca >> sh) & 8'hff;
      xb = (cb >> sh) & 8'hff;
      r[sh +: 8] = (((one - w) * xa + w * xb) >> 16) & 8'hff;
    end
    return r;
  endfunction

  function void note_input(logic [3:0] sel, logic signed [17:0] frac);
    expected_rgb.push_back(predict_rgb(sel, frac));
  endfunction

  function void check_result(logic [7:0] r, logic [7:0] g, logic [7:0] bl);
    logic [23:0] exp_c;
    if (expected_rgb.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: unexpected result %h%h%h", r, g, bl);
      return;
    end
    exp_c = expected_rgb.pop_front();
    if (exp_c !== {r, g, bl}) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: rgb expected %h got %h%h%h", exp_c, r, g, bl);
    end
  endfunction
endclass

module tb_piecewise_linear_color_ramp import plcr_pkg::*;;

  localparam int LATENCY = DEF_MAX_STOPS + DEF_FRAC_BITS + 4;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [IN_W-1:0] fraction_q16 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] red, green, blue;

  color_scoreboard sb;
  logic [3:0] cur_sel;
  int send_idle_pct, stall_pct;
  int cycles = 0;

  piecewise_linear_color_ramp DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Check accepted results and pick the next stall.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(red, green, blue);
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic write_palette(logic [3:0] sel);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= REG_PALETTE; pwdata <= {28'd0, sel};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    cur_sel = sel;
  endtask

  // Hold valid across back-to-back transactions; this task drops it only while idling.
  task automatic send_fraction(logic signed [17:0] frac);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    fraction_q16 <= frac;
    do @(posedge clk); while (!in_ready);
    sb.note_input(cur_sel, frac);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (sb.expected_rgb.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic signed [17:0] rand_fraction();
    int k;
    k = $urandom_range(9);
    if (k < 6) return 18'($urandom_range(65536));
    if (k == 6) return 18'(65536 - $urandom_range(8));
    return 18'($urandom);
  endfunction

  logic signed [17:0] directed[$] = '{18'sh20000, 18'sh1ffff, -18'sd1, 18'sd0, 18'sd1,
    18'sd65535, 18'sd65536, 18'sd65537, 18'sd32768, 18'sd2340, 18'sd1170, 18'sd12345,
    18'sh2aaaa, 18'sh15555};

  initial begin
    sb = new();
    cur_sel = PAL_GENERIC;
    send_idle_pct = 0; stall_pct = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // Reset palette first, then each palette and the out-of-range codes.
    foreach (directed[i]) send_fraction(directed[i]);
    drain();
    for (int s = 0; s < 16; s++) begin
      write_palette(s[3:0]);
      foreach (directed[i]) if (i < 8) send_fraction(directed[i]);
      drain();
    end
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 86; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 86; end
        default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase
      for (int blk = 0; blk < 5; blk++) begin
        write_palette((blk == 0) ? 4'd15 : 4'($urandom_range(15)));
        repeat (60) send_fraction(rand_fraction());
        drain();
      end
    end
    if (sb.mismatches == 0 && sb.expected_rgb.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

// ===== piecewise_linear_color_ramp.f =====
rtl/plcr_pkg.sv
rtl/plcr_seg_cell.sv
rtl/plcr_div_cell.sv
rtl/plcr_blend.sv
rtl/piecewise_linear_color_ramp.sv
rtl/plcr_checker.sv
tb/tb_piecewise_linear_color_ramp.sv
